/* hdl/fpla_pkg.sv */
`default_nettype none
package fpla_pkg;
    localparam int COUNT_WIDTH = 16;
    localparam int NUM_COLS = 12;
    localparam int LED_ROWS = 8;
    localparam int LED_TOTAL = LED_ROWS * NUM_COLS;
    localparam int SEL_W = 7;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_READ = 2'd1,
        MODE_SWAP = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] prog_counter;
        logic [11:0] mem_address;
        logic [11:0] mem_buffer;
        logic [11:0] instr_word;
        logic [12:0] link_acc;
        logic [11:0] mul_quot;
        logic [2:0]  instr_field;
        logic [2:0]  data_field;
        logic [4:0]  step_count;
        logic [4:0]  panel_flags;
        logic [6:0]  led_select;
    } t_in;

    typedef struct packed {
        logic [15:0] led_count;
        logic [11:0] row_state;
        logic [31:0] instr_total;
    } t_out;
endpackage
`default_nettype wire

/* hdl/front_panel_led_accumulator.sv */
`default_nettype none
// channel | signals                      | payload
// in      | i_in_valid / o_in_ready      | fpla_pkg::t_in
// out     | o_out_valid / i_out_ready    | fpla_pkg::t_out
// one request per cycle unless the output stalls: the input register feeds row build,
// count update and read mux, and one result register holds the response
// a request enters whenever the result register is empty or being taken
// synchronous active-low reset clears all counts, rows, totals and the selector
module front_panel_led_accumulator (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  fpla_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output fpla_pkg::t_out o_out
);
    import fpla_pkg::*;

    logic [COUNT_WIDTH-1:0] r_cnt [2][LED_TOTAL];
    logic [11:0] r_rows [2][LED_ROWS];
    logic [31:0] r_insts [2];
    logic r_usel;
    logic r_req_v;
    t_in r_req;
    logic r_out_v;
    t_out r_out;

    logic stall;
    logic [11:0] n_rows [LED_ROWS];
    logic [2:0] op;
    logic running;
    logic copy;
    logic up, pa;
    logic [12:0] sel_mul;
    t_out n_out;

    assign stall = r_out_v && !i_out_ready;
    assign o_in_ready = !(r_req_v && stall);
    assign o_out_valid = r_out_v;
    assign o_out = r_out;
    assign up = r_usel;
    assign pa = ~r_usel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
        end else if (o_in_ready) begin
            r_req_v <= i_in_valid;
        end
        if (o_in_ready) begin
            r_req <= i_in;
        end
    end

    always_comb begin
        op = r_req.instr_word[11:9];
        running = !r_req.panel_flags[2] && !r_req.panel_flags[3];
        copy = !running || r_req.panel_flags[4];
        n_rows[0] = r_req.prog_counter;
        n_rows[1] = r_req.mem_address;
        n_rows[2] = r_req.mem_buffer;
        n_rows[3] = r_req.link_acc[11:0];
        n_rows[4] = r_req.mul_quot;
        n_rows[5] = '0;
        n_rows[5][4'd11 - {1'b0, op}] = 1'b1;
        n_rows[5][1] = (op <= 3'd5) && r_req.instr_word[8];
        n_rows[5][2] = running;
        n_rows[5][3] = running;
        n_rows[6] = '0;
        n_rows[6][7] = running;
        n_rows[6][8] = r_req.panel_flags[1];
        n_rows[6][9] = r_req.panel_flags[0];
        n_rows[6][6:2] = r_req.step_count;
        n_rows[7] = '0;
        n_rows[7][11:9] = r_req.data_field;
        n_rows[7][8:6] = r_req.instr_field;
        n_rows[7][5] = r_req.link_acc[12];
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usel <= 1'b0;
            for (int b = 0; b < 2; b++) begin
                r_insts[b] <= '0;
                for (int r = 0; r < LED_ROWS; r++) begin
                    r_rows[b][r] <= '0;
                end
                for (int i = 0; i < LED_TOTAL; i++) begin
                    r_cnt[b][i] <= '0;
                end
            end
        end else if (r_req_v && !stall) begin
            unique case (t_mode'(r_req.mode))
                MODE_UPDATE: begin
                    r_insts[up] <= r_insts[up] + 32'd1;
                    if (copy) begin
                        r_insts[pa] <= r_insts[up] + 32'd1;
                    end
                    for (int r = 0; r < LED_ROWS; r++) begin
                        r_rows[up][r] <= n_rows[r];
                        if (copy) begin
                            r_rows[pa][r] <= n_rows[r];
                        end
                        for (int c = 0; c < NUM_COLS; c++) begin
                            logic [COUNT_WIDTH-1:0] nc;
                            nc = r_cnt[up][r*NUM_COLS+c];
                            if (n_rows[r][c] && !(&nc)) begin
                                nc = nc + 1'b1;
                            end
                            r_cnt[up][r*NUM_COLS+c] <= nc;
                            if (copy) begin
                                r_cnt[pa][r*NUM_COLS+c] <= nc;
                            end
                        end
                    end
                end
                MODE_SWAP: begin
                    r_insts[pa] <= '0;
                    for (int r = 0; r < LED_ROWS; r++) begin
                        r_rows[pa][r] <= '0;
                    end
                    for (int i = 0; i < LED_TOTAL; i++) begin
                        r_cnt[pa][i] <= '0;
                    end
                    r_usel <= ~r_usel;
                end
                MODE_READ, MODE_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // row of the selected led: select times 43 over 512
        sel_mul = 13'(r_req.led_select) * 13'd43;
        n_out = '0;
        if (t_mode'(r_req.mode) == MODE_READ) begin
            n_out.instr_total = r_insts[pa];
            if (r_req.led_select < SEL_W'(LED_TOTAL)) begin
                n_out.led_count = 16'(r_cnt[pa][r_req.led_select]);
                n_out.row_state = r_rows[pa][sel_mul[11:9]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (!stall) begin
            r_out_v <= r_req_v;
        end
        if (!stall) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire
